// ----- rtl/hbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_pkg
// Shared types and constants for the HDLC-style byte framer with CRC-16.
// ----------------------------------------------------------------------------
package hbf_pkg;

    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 8;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  XOR_MASK    = 8'h20;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_START_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hbf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } hbf_out_t;

    // One classified input word, everything the emitter needs
    typedef struct packed {
        logic        has_start;
        logic [7:0]  open_flag;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] fcs;
        logic [7:0]  close_flag;
    } hbf_job_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_DATA,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_END
    } hbf_phase_t;

endpackage

// ----- rtl/hbf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_front
// Accepts payload words, keeps frame state and the running CRC, holds the
// configuration registers and pushes one job per word into the queue.
// ----------------------------------------------------------------------------
module hbf_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hbf_pkg::hbf_in_t                 s_data,
    input  logic                             cfg_wr_en,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             q_full,
    output logic                             q_push,
    output hbf_pkg::hbf_job_t                q_job
);
    import hbf_pkg::*;

    logic        start_enable_reg;
    logic [7:0]  open_flag_reg;
    logic [7:0]  close_flag_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] crc_seed;
    logic [15:0] crc_new;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;
    assign crc_seed = frame_open_reg ? crc_reg : CRC_INIT;
    assign crc_new  = crc_byte(crc_seed, s_data.data_byte);

    always_comb begin
        q_job.has_start  = !frame_open_reg && start_enable_reg;
        q_job.open_flag  = open_flag_reg;
        q_job.data_byte  = s_data.data_byte;
        q_job.last_byte  = s_data.last_byte;
        q_job.fcs        = ~crc_new;
        q_job.close_flag = close_flag_reg;
    end

    always_comb begin
        crc_next        = crc_reg;
        frame_open_next = frame_open_reg;
        if (q_push) begin
            // close the frame on its last word and rearm the CRC
            crc_next        = s_data.last_byte ? CRC_INIT : crc_new;
            frame_open_next = !s_data.last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_enable_reg <= 1'b1;
            open_flag_reg    <= FLAG_BYTE;
            close_flag_reg   <= FLAG_BYTE;
            crc_reg          <= CRC_INIT;
            frame_open_reg   <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            frame_open_reg <= frame_open_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_ENABLE: start_enable_reg <= cfg_wdata[0];
                    REG_START_CHAR:   open_flag_reg    <= cfg_wdata[7:0];
                    REG_END_CHAR:     close_flag_reg   <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/hbf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_queue
// Short job queue between the front and the emitter.
// ----------------------------------------------------------------------------
module hbf_queue #(
    parameter int DEPTH = hbf_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hbf_pkg::hbf_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output hbf_pkg::hbf_job_t head_job
);
    import hbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbf_job_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/hbf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_back
// Emitter: walks each job through start (if any), payload, FCS and end (last
// word only), escaping bytes; one output word per cycle unless m_ready stalls.
// ----------------------------------------------------------------------------
module hbf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  hbf_pkg::hbf_job_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output hbf_pkg::hbf_out_t m_data
);
    import hbf_pkg::*;

    hbf_job_t   job_reg;
    hbf_job_t   job_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    hbf_phase_t phase_reg;
    hbf_phase_t phase_next;
    logic       esc_pend_reg;
    logic       esc_pend_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    hbf_out_t   m_data_reg;
    hbf_out_t   m_data_next;

    logic       adv;
    logic       emit;
    logic [7:0] sel_byte;
    logic       sel_esc;
    logic       byte_done;
    logic       job_end;
    logic       need_load;
    hbf_out_t   word;

    assign adv  = !m_valid_reg || m_ready;
    assign emit = job_valid_reg && adv;

    always_comb begin
        case (phase_reg)
            PH_FCS_LO: sel_byte = job_reg.fcs[7:0];
            PH_FCS_HI: sel_byte = job_reg.fcs[15:8];
            default:   sel_byte = job_reg.data_byte;
        endcase
    end

    assign sel_esc = (sel_byte == ESC_BYTE) || (sel_byte == FLAG_BYTE);

    always_comb begin
        word      = '0;
        byte_done = 1'b1;
        job_end   = 1'b0;
        unique case (phase_reg)
            PH_START: begin
                word.out_byte = job_reg.open_flag;
            end
            PH_DATA, PH_FCS_LO, PH_FCS_HI: begin
                if (esc_pend_reg) begin
                    word.out_byte = sel_byte ^ XOR_MASK;
                end else if (sel_esc) begin
                    word.out_byte = ESC_BYTE;
                    byte_done     = 1'b0;
                end else begin
                    word.out_byte = sel_byte;
                end
                job_end = byte_done && (phase_reg == PH_DATA) && !job_reg.last_byte;
            end
            PH_END: begin
                word.out_byte  = job_reg.close_flag;
                word.frame_end = 1'b1;
                job_end        = 1'b1;
            end
            default: ;
        endcase
        word.run_last = job_end;
    end

    assign need_load = !job_valid_reg || (emit && job_end);
    assign q_pop     = need_load && !q_empty;

    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        esc_pend_next  = esc_pend_reg;
        if (emit) begin
            esc_pend_next = !byte_done;
            if (byte_done) begin
                unique case (phase_reg)
                    PH_START:  phase_next = PH_DATA;
                    PH_DATA:   phase_next = PH_FCS_LO;
                    PH_FCS_LO: phase_next = PH_FCS_HI;
                    PH_FCS_HI: phase_next = PH_END;
                    PH_END:    phase_next = PH_DATA;
                    default:   phase_next = PH_DATA;
                endcase
            end
        end
        if (need_load) begin
            job_valid_next = !q_empty;
            job_next       = q_head;
            phase_next     = q_head.has_start ? PH_START : PH_DATA;
            esc_pend_next  = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv) begin
            m_valid_next = job_valid_reg;
            m_data_next  = word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_DATA;
            esc_pend_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            esc_pend_reg  <= esc_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/hdlc_style_byte_framer_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_style_byte_framer_crc16
// HDLC-style byte framer: start character, escaped payload, CRC-16/X.25
// FCS (low byte first, escaped) and end character.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Word
// s_        in   s_valid/s_ready    data_byte, last_byte
// m_        out  m_valid/m_ready    out_byte, frame_end, run_last
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// The emitter produces one output word per cycle unless m_ready stalls it: a
// plain payload byte gives one word, an escaped byte two; a last word adds the
// two FCS bytes and end character, a frame's first word the start character
// if enabled. Input is taken while the job queue has room; the front and the
// emitter stall independently. aresetn is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module hdlc_style_byte_framer_crc16 #(
    parameter int QUEUE_DEPTH = hbf_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hbf_pkg::hbf_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hbf_pkg::hbf_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import hbf_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_empty;
    hbf_job_t q_job;
    hbf_job_t q_head;

    hbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    hbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head)
    );

    hbf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/hbf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_checker
// Port-level checks for the framer, bound to the top level.
// ----------------------------------------------------------------------------
module hbf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input hbf_pkg::hbf_out_t m_data
);
    import hbf_pkg::*;

    // hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // the end character always closes the run of its input word
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.run_last)
        else $error("frame_end without run_last");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid straight after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready straight after reset");

endmodule

bind hdlc_style_byte_framer_crc16 hbf_checker u_hbf_checker (.*);

// ----- tb/sv/hbf_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbf_frame_checker
// Watches both channels and the register port of the byte framer. It tracks
// the framing registers, the running CRC-16/X.25 and the open-frame flag,
// builds the escaped byte stream each accepted input word should produce and
// compares every output word, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module hbf_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  hbf_pkg::hbf_in_t                s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  hbf_pkg::hbf_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              pending_words,
    output int                              words_checked,
    output int                              frames_checked
);
    import hbf_pkg::*;

    logic        start_en;
    logic [7:0]  start_chr;
    logic [7:0]  end_chr;
    logic [15:0] crc_run;
    logic        in_frame;

    hbf_out_t    expected_stream[$];

    initial begin
        fail_count     = 0;
        pending_words  = 0;
        words_checked  = 0;
        frames_checked = 0;
    end

    function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic fend);
        hbf_out_t w;
        w.out_byte  = b;
        w.frame_end = fend;
        w.run_last  = 1'b0;
        expected_stream.push_back(w);
    endtask

    task automatic queue_stuffed(input logic [7:0] b);
        if (b == ESC_BYTE || b == FLAG_BYTE) begin
            queue_byte(ESC_BYTE, 1'b0);
            queue_byte(b ^ XOR_MASK, 1'b0);
        end else begin
            queue_byte(b, 1'b0);
        end
    endtask

    task automatic predict_framed_bytes(input hbf_in_t w);
        logic [15:0] fcs;
        hbf_out_t    tail;
        if (!in_frame) begin
            crc_run = CRC_INIT;
            if (start_en)
                queue_byte(start_chr, 1'b0);
            in_frame = 1'b1;
        end
        crc_run = crc16_x25_byte(crc_run, w.data_byte);
        queue_stuffed(w.data_byte);
        if (w.last_byte) begin
            fcs = ~crc_run;
            queue_stuffed(fcs[7:0]);
            queue_stuffed(fcs[15:8]);
            queue_byte(end_chr, 1'b1);
            crc_run  = CRC_INIT;
            in_frame = 1'b0;
        end
        // mark the final word this input causes
        tail = expected_stream.pop_back();
        tail.run_last = 1'b1;
        expected_stream.push_back(tail);
    endtask

    always @(posedge aclk) begin : watch
        hbf_out_t want;
        if (!aresetn) begin
            start_en  = 1'b1;
            start_chr = FLAG_BYTE;
            end_chr   = FLAG_BYTE;
            crc_run   = CRC_INIT;
            in_frame  = 1'b0;
            expected_stream.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_ENABLE: start_en  = cfg_wdata[0];
                    REG_START_CHAR:   start_chr = cfg_wdata[7:0];
                    REG_END_CHAR:     end_chr   = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_framed_bytes(s_data);
            if (m_valid && m_ready) begin
                if (expected_stream.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word %02h frame_end %0b run_last %0b",
                             $time, m_data.out_byte, m_data.frame_end, m_data.run_last);
                end else begin
                    want = expected_stream.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        fail_count++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, m_data.out_byte);
                    end
                    if (m_data.frame_end !== want.frame_end) begin
                        fail_count++;
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $time, want.frame_end, m_data.frame_end);
                    end
                    if (m_data.run_last !== want.run_last) begin
                        fail_count++;
                        $display("%0t: run_last expected %0b, got %0b",
                                 $time, want.run_last, m_data.run_last);
                    end
                    words_checked++;
                    if (want.frame_end)
                        frames_checked++;
                end
            end
        end
        pending_words <= expected_stream.size();
    end

endmodule

// ----- tb/sv/tb_hdlc_style_byte_framer_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_style_byte_framer_crc16
// Drives payload frames into the byte framer under changing framing
// registers, with random gaps on the input and random back-pressure on the
// output; the checker beside the block predicts and compares the stream.
// ----------------------------------------------------------------------------
module tb_hdlc_style_byte_framer_crc16;
    import hbf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SIDE_SRC   = 0;
    localparam int SIDE_SINK  = 1;
    localparam int WORDS_GOAL = 300;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    hbf_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    hbf_out_t               m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending_words;
    int words_checked;
    int frames_checked;
    int words_sent = 0;
    int settings   = 0;

    int burst_left[2]  = '{0, 0};
    bit burst_quiet[2] = '{1'b0, 1'b0};

    hdlc_style_byte_framer_crc16 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    hbf_frame_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .words_checked  (words_checked),
        .frames_checked (frames_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gaps come in stretches: some stretches run flat out, others idle at random
    function automatic int draw_gap(input int side);
        if (burst_left[side] == 0) begin
            burst_left[side]  = $urandom_range(8, 40);
            burst_quiet[side] = ($urandom_range(0, 2) == 0);
        end
        burst_left[side]--;
        return burst_quiet[side] ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int      gap;
        hbf_in_t w;
        gap = draw_gap(SIDE_SRC);
        w.data_byte = b;
        w.last_byte = last;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_frame(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_word(bytes[i], i == bytes.size() - 1);
    endtask

    // Hold until every expected word has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_framing(input logic en, input logic [7:0] sc, input logic [7:0] ec);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_ENABLE;
        cfg_wdata <= {7'($urandom), en};
        @(posedge aclk);
        cfg_index <= REG_START_CHAR;
        cfg_wdata <= sc;
        @(posedge aclk);
        cfg_index <= REG_END_CHAR;
        cfg_wdata <= ec;
        // write to the unused index must leave everything alone
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return ESC_BYTE;
            1:       return FLAG_BYTE;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        logic [7:0] bytes[$];
        int         len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        repeat (len) bytes.push_back(pick_byte());
        send_frame(bytes);
    endtask

    // Output side: random back-pressure per word
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(SIDE_SINK);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset framing: flag characters, start enabled
        send_frame('{FLAG_BYTE});
        send_frame('{8'h00, 8'hFF, ESC_BYTE, 8'h7C, 8'h7F, 8'h5D, FLAG_BYTE});
        drain();

        // no start character; start and end set to the escape byte itself
        set_framing(1'b0, ESC_BYTE, ESC_BYTE);
        send_frame('{FLAG_BYTE, XOR_MASK, 8'h01});
        send_frame('{ESC_BYTE});
        drain();

        set_framing(1'b1, 8'h00, 8'hFF);
        send_frame('{8'hA5});
        send_frame('{8'hFF, 8'h00});
        drain();

        set_framing(1'b1, 8'hFF, 8'h00);
        send_frame('{8'h80, FLAG_BYTE, ESC_BYTE, 8'h01});
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_framing(1'b0, 8'hFF, 8'h00);
                1:       set_framing(1'b1, 8'h00, 8'hFF);
                2:       set_framing(1'($urandom), 8'($urandom), 8'($urandom));
                default: set_framing(1'b1, FLAG_BYTE, FLAG_BYTE);
            endcase
            while (words_sent < 16 + (phase + 1) * WORDS_GOAL / 4)
                send_random_frame();
            drain();
        end

        while (pending_words != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d payload words under %0d register settings;", words_sent, settings);
        $display("checked %0d output words closing %0d frames.", words_checked, frames_checked);
        if (fail_count == 0 && pending_words == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d words still expected", pending_words);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
